>>> rtl/core/lru_key_set_defines.svh
// Assertion macros shared by the LRU key set RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LRU_KEY_SET_DEFINES_SVH
`define LRU_KEY_SET_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LKS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lru_key_set: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lru_key_set: next-cycle check failed");

`endif

>>> rtl/core/lks_pkg.sv
// Shared types, constants and elaboration helpers for the LRU key set.
// No dependencies; used by lks_cell, lks_hit_tree and lru_key_set.
package lks_pkg;

  localparam int unsigned ENTRIES_DEF  = 512;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned CAP_W        = 10;
  localparam logic [CAP_W-1:0] CAP_RESET = 10'd512;
  localparam int unsigned TREE_FANIN   = 8;

  // Per-cell control: load latches a key compare, shift takes the neighbor's entry.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // Number of nodes at a given level of a fanin-8 reduction over n leaves.
  function automatic int unsigned level_nodes(int unsigned n, int unsigned lvl);
    int unsigned cnt;
    cnt = n;
    for (int unsigned l = 0; l < lvl; l++) begin
      cnt = (cnt + TREE_FANIN - 1) / TREE_FANIN;
    end
    return cnt;
  endfunction

  // Levels of a fanin-8 tree needed to reduce n leaves to one node.
  function automatic int unsigned clog8(int unsigned n);
    int unsigned cnt;
    int unsigned lvl;
    cnt = n;
    lvl = 0;
    while (cnt > 1) begin
      cnt = (cnt + TREE_FANIN - 1) / TREE_FANIN;
      lvl++;
    end
    return lvl;
  endfunction

endpackage

>>> rtl/core/lks_cell.sv
// One recency-ordered slot of the LRU key set: key, valid and a compare flag.
// Depends on lks_pkg for the cell control struct.
module lks_cell import lks_pkg::*; #(
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cell_ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0] cmp_key_i,
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic                prev_valid_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                valid_o,
  output logic                match_o
);

  logic [KEY_BITS-1:0] key_q;
  logic                valid_q;
  logic                match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.shift) begin
        valid_q <= prev_valid_i;
      end
      if (ctl_i.load) begin
        match_q <= valid_q && (key_q == cmp_key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      key_q <= prev_key_i;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

>>> rtl/core/lks_hit_tree.sv
// Registered fanin-8 OR tree turning the one-hot cell match vector into hit + index.
// Depends on lks_pkg for the tree sizing helpers.
module lks_hit_tree import lks_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  logic               clk_i,
  input  logic [ENTRIES-1:0] match_i,
  output logic               hit_o,
  output logic [IDX_W-1:0]   idx_o
);

  localparam int unsigned LEVELS = clog8(ENTRIES);
  localparam int unsigned NODES1 = level_nodes(ENTRIES, 1);

  logic             tree_hit_q [LEVELS][NODES1];
  logic [IDX_W-1:0] tree_idx_q [LEVELS][NODES1];

  // Matches are one-hot, so OR-ing the leaf positions yields the matching index.
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int unsigned CHILDREN = level_nodes(ENTRIES, l);
    localparam int unsigned NODES    = level_nodes(ENTRIES, l + 1);

    logic             node_hit [NODES1];
    logic [IDX_W-1:0] node_idx [NODES1];

    if (l == 0) begin : g_leaf
      always_comb begin
        for (int k = 0; k < NODES1; k++) begin
          node_hit[k] = 1'b0;
          node_idx[k] = '0;
          for (int c = 0; c < TREE_FANIN; c++) begin
            if (k * TREE_FANIN + c < CHILDREN) begin
              node_hit[k] = node_hit[k] | match_i[k * TREE_FANIN + c];
              node_idx[k] = node_idx[k] |
                  (match_i[k * TREE_FANIN + c] ? IDX_W'(k * TREE_FANIN + c) : '0);
            end
          end
        end
      end
    end else begin : g_inner
      always_comb begin
        for (int k = 0; k < NODES1; k++) begin
          node_hit[k] = 1'b0;
          node_idx[k] = '0;
          if (k < NODES) begin
            for (int c = 0; c < TREE_FANIN; c++) begin
              if (k * TREE_FANIN + c < CHILDREN) begin
                node_hit[k] = node_hit[k] | tree_hit_q[l-1][k * TREE_FANIN + c];
                node_idx[k] = node_idx[k] | tree_idx_q[l-1][k * TREE_FANIN + c];
              end
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < NODES1; k++) begin
        tree_hit_q[l][k] <= node_hit[k];
        tree_idx_q[l][k] <= node_idx[k];
      end
    end
  end

  assign hit_o = tree_hit_q[LEVELS-1][0];
  assign idx_o = tree_idx_q[LEVELS-1][0];

endmodule

>>> rtl/core/lru_key_set.sv
// LRU key set top level: sequencer, occupancy, capacity register, output register.
// Depends on lks_pkg, lks_cell, lks_hit_tree and lru_key_set_defines.svh.
//
// Usage:
//   s_axis carries one request per transfer: tdata holds the key, tuser the mode
//   (0 = lookup, 1 = insert). m_axis returns one result per request: tdata bit 0
//   is was_present, bit 1 is evicted. cfg_* writes the capacity register and is
//   always ready; write it only while no request is outstanding.
//   Keys sit in a chain of cells ordered by recency, cell 0 most recent. A request
//   is compared against every cell at the transfer edge, the one-hot match goes
//   through a registered fanin-8 tree of L = ceil(log8(ENTRIES)) levels, and on a
//   hit or an insert the chain then shifts by one up to the hit or fill point.
//   Each request occupies the block while its match passes the tree levels and
//   through its update step, where the result is registered as the chain shifts.
//   One request is in flight at a time.
//   The next request is taken while a result waits in the output register; if the
//   receiver still holds off, the block waits in its update step.
//   Reset empties the set and loads capacity 512; no clearing pass is needed.
module lru_key_set import lks_pkg::*; #(
  parameter int unsigned ENTRIES  = ENTRIES_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  localparam int unsigned TDATA_W = ((KEY_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i,      // capacity
  // request stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [TDATA_W-1:0] s_axis_tdata_i,  // key, zero padded
  input  logic [0:0]         s_axis_tuser_i,  // mode
  // result stream
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o   // was_present, evicted, zero padded
);

`include "lru_key_set_defines.svh"

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int unsigned LEVELS = clog8(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(LEVELS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [KEY_BITS-1:0] key_q;
  logic                mode_q;
  logic [CAP_W-1:0]    cap_q;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic                out_valid_q;
  logic                out_present_q;
  logic                out_evicted_q;

  logic [KEY_BITS-1:0] cell_key [ENTRIES];
  logic [ENTRIES-1:0]  cell_valid;
  logic [ENTRIES-1:0]  cell_match;
  cell_ctl_t           cell_ctl [ENTRIES];

  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                s_fire;
  logic                apply_fire;
  logic                evict;
  logic                grow;
  logic [CAP_W-1:0]    cap_eff;
  logic [IDX_W-1:0]    stop;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign apply_fire      = (state_q == ST_APPLY) && (!out_valid_q || m_axis_tready_i);

  // Capacity zero acts as one; a full chain always evicts.
  assign cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;
  assign evict   = (CMP_W'(occ_q) >= CMP_W'(cap_eff)) || (occ_q == OCC_W'(ENTRIES));
  assign grow    = !hit && mode_q && !evict;

  // Last cell that takes its neighbor's entry this update.
  always_comb begin
    if (hit) begin
      stop = hit_idx;
    end else if (evict) begin
      stop = IDX_W'(occ_q - OCC_W'(1));
    end else begin
      stop = IDX_W'(occ_q);
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic                prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    assign cell_ctl[i].load  = s_fire;
    assign cell_ctl[i].shift = apply_fire && (hit || mode_q) && (IDX_W'(i) <= stop);

    lks_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[i]),
      .cmp_key_i    (s_axis_tdata_i[KEY_BITS-1:0]),
      .prev_key_i   (prev_key),
      .prev_valid_i (prev_valid),
      .key_o        (cell_key[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  lks_hit_tree #(
    .ENTRIES (ENTRIES)
  ) u_hit_tree (
    .clk_i   (clk_i),
    .match_i (cell_match),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    occ_d   = occ_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_WAIT;
          cnt_d   = '0;
        end
      end
      ST_WAIT: begin
        if (cnt_q == CNT_W'(LEVELS - 1)) begin
          state_d = ST_APPLY;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_APPLY: begin
        if (apply_fire) begin
          state_d = ST_IDLE;
          if (grow) begin
            occ_d = occ_q + OCC_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      occ_q   <= occ_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (apply_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      key_q  <= s_axis_tdata_i[KEY_BITS-1:0];
      mode_q <= s_axis_tuser_i[0];
    end
    if (apply_fire) begin
      out_present_q <= hit;
      out_evicted_q <= !hit && mode_q && evict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_evicted_q, out_present_q};

  // Keys are unique in the chain, so at most one cell can match.
  `LKS_ASSERT_IMPL(a_match_onehot, state_q != ST_IDLE, $onehot0(cell_match))
  // The number of valid cells matches the occupancy count.
  `LKS_ASSERT_IMPL(a_valid_count, 1'b1, $countones(cell_valid) == int'(occ_q))
  `LKS_ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= OCC_W'(ENTRIES))
  // An insert of a new key without eviction adds exactly one entry.
  `LKS_ASSERT_NEXT(a_occ_grow, apply_fire && grow, occ_q == $past(occ_q) + OCC_W'(1))

endmodule

>>> tb/sv/lru_key_set_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_set: a directed table, then random phases over several
// capacities. Recency is predicted with a key queue, most recent first. Needs lks_pkg and the RTL.
module lru_key_set_test;
  import lks_pkg::*;

  localparam int unsigned SLOTS         = ENTRIES_DEF;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int          SIDE_SEND     = 0;
  localparam int          SIDE_RECV     = 1;

  typedef enum logic {MODE_LOOKUP = 1'b0, MODE_INSERT = 1'b1} req_mode_e;
  typedef enum logic {ROW_REQ = 1'b0, ROW_CAP = 1'b1} row_kind_e;

  // bit 1: was_present, bit 0: evicted
  typedef struct packed {
    logic was_present;
    logic evicted;
  } lookup_flags_t;

  typedef struct packed {
    row_kind_e        kind;
    req_mode_e        mode;
    logic [31:0]      key;
    logic [CAP_W-1:0] cap;
    logic             typed;
    lookup_flags_t    flags;
  } table_row_t;

  localparam int N_ROWS = 22;
  // Store empty and capacity 512 at the top of the table.
  localparam table_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_REQ, MODE_LOOKUP, 32'h0000_0000, 10'd0,    1'b1, 2'b00}, // lookup in empty store
    '{ROW_REQ, MODE_INSERT, 32'h0000_0000, 10'd0,    1'b1, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'h0000_0000, 10'd0,    1'b1, 2'b10},
    '{ROW_REQ, MODE_INSERT, 32'hFFFF_FFFF, 10'd0,    1'b1, 2'b00},
    '{ROW_REQ, MODE_INSERT, 32'hFFFF_FFFF, 10'd0,    1'b1, 2'b10}, // insert of held key
    '{ROW_REQ, MODE_LOOKUP, 32'h0000_0000, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'h5555_5555, 10'd0,    1'b1, 2'b00}, // miss leaves state alone
    '{ROW_REQ, MODE_INSERT, 32'hAAAA_AAAA, 10'd0,    1'b0, 2'b00},
    '{ROW_CAP, MODE_LOOKUP, 32'h0000_0000, 10'd1,    1'b0, 2'b00}, // below occupancy
    '{ROW_REQ, MODE_INSERT, 32'h0000_0001, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'hFFFF_FFFF, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_INSERT, 32'h0000_0000, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_INSERT, 32'h8000_0000, 10'd0,    1'b0, 2'b00},
    '{ROW_CAP, MODE_LOOKUP, 32'h0000_0000, 10'd0,    1'b0, 2'b00}, // zero acts as one
    '{ROW_REQ, MODE_INSERT, 32'h7FFF_FFFF, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'h8000_0000, 10'd0,    1'b0, 2'b00},
    '{ROW_CAP, MODE_LOOKUP, 32'h0000_0000, 10'd1023, 1'b0, 2'b00}, // clipped to entries
    '{ROW_REQ, MODE_INSERT, 32'h1234_5678, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'h1234_5678, 10'd0,    1'b1, 2'b10},
    '{ROW_CAP, MODE_LOOKUP, 32'h0000_0000, 10'd2,    1'b0, 2'b00},
    '{ROW_REQ, MODE_INSERT, 32'h0F0F_0F0F, 10'd0,    1'b0, 2'b00},
    '{ROW_REQ, MODE_LOOKUP, 32'h0F0F_0F0F, 10'd0,    1'b1, 2'b10}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;
  logic             s_valid;
  logic             s_ready;
  logic [31:0]      s_data;   // key
  logic [0:0]       s_user;   // mode
  logic             m_valid;
  logic             m_ready;
  logic [7:0]       m_data;   // was_present, evicted, zero padded

  logic [31:0]      recency_list [$];  // index 0 is most recent
  logic [31:0]      phase_keys [$];
  logic [CAP_W-1:0] capacity_reg;
  lookup_flags_t    awaited_flags [$];
  int unsigned      failures;
  int unsigned      results_seen;
  int unsigned      idle_cycles;
  int               gap_run [2];
  bit               gap_steady [2];
  bit               held_once;

  lru_key_set uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_capacity();
    int unsigned c;
    c = capacity_reg;
    if (c == 0) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // Applies one request to the recency list and returns the flags it should report.
  function automatic lookup_flags_t lru_access(req_mode_e mode, logic [31:0] key);
    lookup_flags_t f;
    int            hit;
    f   = '0;
    hit = -1;
    foreach (recency_list[i]) if (recency_list[i] == key) hit = i;
    if (hit >= 0) begin
      recency_list.delete(hit);
      recency_list.push_front(key);
      f.was_present = 1'b1;
    end else if (mode == MODE_INSERT) begin
      if (recency_list.size() > 0 && recency_list.size() >= eff_capacity()) begin
        void'(recency_list.pop_back());
        f.evicted = 1'b1;
      end
      recency_list.push_front(key);
    end
    return f;
  endfunction

  // Splits traffic into stretches, each either without gaps or with random gaps.
  function automatic int unsigned draw_gap(int side);
    if (gap_run[side] == 0) begin
      gap_steady[side] = ($urandom_range(0, 2) == 0);
      gap_run[side]    = $urandom_range(10, 40);
    end
    gap_run[side]--;
    return gap_steady[side] ? 0 : $urandom_range(0, 5);
  endfunction

  // Called at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic push_request(req_mode_e mode, logic [31:0] key, bit typed,
                              lookup_flags_t flags);
    int unsigned   gap;
    lookup_flags_t predicted;
    gap = draw_gap(SIDE_SEND);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= key;
    s_user  <= mode;
    do @(posedge clk); while (!s_ready);
    predicted = lru_access(mode, key);
    awaited_flags.push_back(typed ? flags : predicted);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    s_valid <= 1'b0;
    while (awaited_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic random_request(int unsigned fresh_pct, int unsigned insert_pct);
    req_mode_e   mode;
    logic [31:0] key;
    mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_LOOKUP;
    if ($urandom_range(0, 99) < fresh_pct) key = $urandom;
    else key = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
    push_request(mode, key, 1'b0, '0);
  endtask

  // Key pool: up to half taken from the most recent held keys, the rest new.
  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned items, int unsigned pool_size,
                           int unsigned fresh_pct, int unsigned insert_pct, bit fill);
    write_capacity(cap);
    phase_keys.delete();
    foreach (recency_list[i]) if (phase_keys.size() < pool_size / 2)
      phase_keys.push_back(recency_list[i]);
    while (phase_keys.size() < pool_size) phase_keys.push_back($urandom);
    while (fill && recency_list.size() < SLOTS) random_request(fresh_pct, insert_pct);
    repeat (items) random_request(fresh_pct, insert_pct);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = '0;
    failures  = 0;
    capacity_reg = CAP_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_CAP) write_capacity(DIRECTED_ROWS[r].cap);
      else push_request(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].typed,
                        DIRECTED_ROWS[r].flags);
    end
    run_phase(10'd0,    12, 4,  10, 60, 1'b0);
    run_phase(10'd1,    12, 3,  10, 60, 1'b0);
    run_phase(10'd5,    25, 10, 10, 55, 1'b0);
    run_phase(10'd29,   30, 50, 10, 60, 1'b0);
    run_phase(10'd2,    12, 8,  20, 60, 1'b0);  // lowered under occupancy
    run_phase(10'd1023, 20, 20, 97, 97, 1'b1);  // fill the whole store, then evict
    run_phase(10'd512,  20, 60, 30, 60, 1'b0);
    s_valid <= 1'b0;
    while (awaited_flags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Result side; holds off once for a long stretch so the request side backs up.
  initial begin
    int unsigned gap;
    m_ready   = 1'b0;
    held_once = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_once && results_seen >= 60) begin
        held_once = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = draw_gap(SIDE_RECV);
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  initial results_seen = 0;

  always @(posedge clk) begin
    lookup_flags_t want;
    if (rst_n && m_valid && m_ready) begin
      results_seen++;
      if (awaited_flags.size() == 0) begin
        $error("result transfer with no request outstanding");
        failures++;
      end else begin
        want = awaited_flags[0];
        awaited_flags.delete(0);
        if (m_data[0] !== want.was_present) begin
          $error("was_present: expected %0d, got %0d", want.was_present, m_data[0]);
          failures++;
        end
        if (m_data[1] !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, m_data[1]);
          failures++;
        end
      end
    end
  end

  initial idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule
